// ----- hdl/agu_pkg.sv -----
`default_nettype none

package agu_pkg;

    // Table depth used when the top level is not given another value.
    localparam int DEFAULT_TABLE_ENTRIES = 64;

    // Result status codes.
    typedef logic [1:0] t_status;
    localparam t_status STATUS_NEW     = 2'd0;
    localparam t_status STATUS_UPDATED = 2'd1;
    localparam t_status STATUS_DROPPED = 2'd2;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
    localparam logic [63:0] SUM_MAX   = 64'hFFFF_FFFF_FFFF_FFFF;

    // One input item.
    typedef struct packed {
        logic [63:0] stack_key;
        logic [63:0] alloc_size;
        logic [63:0] block_address;
    } t_in_item;

    // One result item.
    typedef struct packed {
        t_status     status;
        logic [31:0] alloc_count;
        logic [63:0] size_sum;
        logic [63:0] size_peak;
        logic [63:0] peak_address;
    } t_out_item;

    // One table entry as held in the table memory.
    typedef struct packed {
        logic [63:0] key;
        logic [31:0] count;
        logic [63:0] sum;
        logic [63:0] peak;
        logic [63:0] peak_addr;
    } t_record;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;    // capture the accepted input item
        logic    commit;  // write the table and load the result register
        t_status kind;    // outcome of the lookup
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic key_match;  // registered table read holds the current key
        logic out_free;   // result register can take a new item this cycle
    } t_stat;

endpackage

`default_nettype wire

// ----- hdl/agu_stream_if.sv -----
`default_nettype none

// Valid/ready channel carrying one item of type t_payload.
interface agu_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hdl/agu_datapath.sv -----
`default_nettype none

module agu_datapath #(
    parameter int TABLE_ENTRIES = agu_pkg::DEFAULT_TABLE_ENTRIES,
    parameter int IDX_W         = $clog2(TABLE_ENTRIES)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire agu_pkg::t_in_item    i_in_payload,
    input  wire logic                 i_out_ready,
    input  wire agu_pkg::t_cmd        i_cmd,
    input  wire logic [IDX_W-1:0]     i_rd_addr,
    input  wire logic [IDX_W-1:0]     i_wr_addr,
    output agu_pkg::t_stat            o_stat,
    output logic                      o_out_valid,
    output agu_pkg::t_out_item        o_out_payload
);
    import agu_pkg::*;

    t_record     r_table [TABLE_ENTRIES];
    t_record     r_rd_data;
    t_in_item    r_item;
    logic        r_out_valid;
    t_out_item   r_out;

    t_record     n_rec;
    t_out_item   n_out;
    logic        w_wr_en;
    logic [64:0] w_sum_wide;

    // Input item capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_payload;
        end
    end

    // Table memory: one write port, one registered read port.
    assign w_wr_en = i_cmd.commit && (i_cmd.kind != STATUS_DROPPED);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_table[i_wr_addr] <= n_rec;
        end
        r_rd_data <= r_table[i_rd_addr];
    end

    // Updated record: saturating count and sum, strictly larger size takes the peak.
    assign w_sum_wide = {1'b0, r_rd_data.sum} + {1'b0, r_item.alloc_size};

    always_comb begin
        n_rec.key = r_item.stack_key;
        if (i_cmd.kind == STATUS_UPDATED) begin
            n_rec.count = (r_rd_data.count == COUNT_MAX) ? COUNT_MAX
                                                         : r_rd_data.count + 32'd1;
            n_rec.sum   = w_sum_wide[64] ? SUM_MAX : w_sum_wide[63:0];
            if (r_rd_data.peak < r_item.alloc_size) begin
                n_rec.peak      = r_item.alloc_size;
                n_rec.peak_addr = r_item.block_address;
            end else begin
                n_rec.peak      = r_rd_data.peak;
                n_rec.peak_addr = r_rd_data.peak_addr;
            end
        end else begin
            n_rec.count     = 32'd1;
            n_rec.sum       = r_item.alloc_size;
            n_rec.peak      = r_item.alloc_size;
            n_rec.peak_addr = r_item.block_address;
        end
    end

    // Result item; a dropped item reports zeros.
    always_comb begin
        n_out.status = i_cmd.kind;
        if (i_cmd.kind == STATUS_DROPPED) begin
            n_out.alloc_count  = '0;
            n_out.size_sum     = '0;
            n_out.size_peak    = '0;
            n_out.peak_address = '0;
        end else begin
            n_out.alloc_count  = n_rec.count;
            n_out.size_sum     = n_rec.sum;
            n_out.size_peak    = n_rec.peak;
            n_out.peak_address = n_rec.peak_addr;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    assign o_stat.key_match = (r_rd_data.key == r_item.stack_key);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_out_payload    = r_out;

endmodule

`default_nettype wire

// ----- hdl/agu_controller.sv -----
`default_nettype none

module agu_controller #(
    parameter int TABLE_ENTRIES = agu_pkg::DEFAULT_TABLE_ENTRIES,
    parameter int IDX_W         = $clog2(TABLE_ENTRIES),
    parameter int FILL_W        = $clog2(TABLE_ENTRIES + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire agu_pkg::t_stat       i_stat,
    output agu_pkg::t_cmd             o_cmd,
    output logic [IDX_W-1:0]          o_rd_addr,
    output logic [IDX_W-1:0]          o_wr_addr
);
    import agu_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(TABLE_ENTRIES);

    logic [1:0]        r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [FILL_W-1:0] r_fill, n_fill;
    t_status           r_kind, n_kind;
    logic              w_accept;
    logic              w_last;

    assign w_accept = i_in_valid && (r_state == ST_IDLE);
    // The entry now read back is the last filled one.
    assign w_last   = (FILL_W'(r_idx) + FILL_W'(1)) == r_fill;

    // Next-state logic; entries fill in order, so filled entries are 0 to fill-1.
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_fill     = r_fill;
        n_kind     = r_kind;
        o_cmd      = '0;
        o_cmd.kind = r_kind;
        o_rd_addr  = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_idx      = '0;
                    o_rd_addr  = '0;
                    if (r_fill == '0) begin
                        n_kind  = STATUS_NEW;
                        n_state = ST_COMMIT;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (i_stat.key_match) begin
                    n_kind  = STATUS_UPDATED;
                    n_state = ST_COMMIT;
                end else if (w_last) begin
                    n_kind  = (r_fill == FILL_FULL) ? STATUS_DROPPED : STATUS_NEW;
                    n_state = ST_COMMIT;
                end else begin
                    n_idx     = r_idx + IDX_W'(1);
                    o_rd_addr = r_idx + IDX_W'(1);
                end
            end
            ST_COMMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                    if (r_kind == STATUS_NEW) begin
                        n_fill = r_fill + FILL_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Write address: the matching entry on a hit, the next free entry otherwise.
    assign o_wr_addr  = (r_kind == STATUS_UPDATED) ? r_idx : r_fill[IDX_W-1:0];
    assign o_in_ready = (r_state == ST_IDLE);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_fill  <= '0;
            r_kind  <= STATUS_NEW;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_fill  <= n_fill;
            r_kind  <= n_kind;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/allocation_groupby_aggregator_unit.sv -----
`default_nettype none

// Keyed aggregation table with count, saturating sum and peak size per key.
// Each input item is looked up by stack_key in a table of TABLE_ENTRIES records
// held in a single-port-read memory. Filled entries are scanned one per cycle
// from entry 0, up to the matching entry or, on a miss, through all filled
// entries, so at most TABLE_ENTRIES are examined. The table write and the
// result load follow the scan, and the next item is accepted only after that,
// so an item is not taken while an earlier one is still in its lookup. When a
// result still waits in the output register and the output is not ready, the
// update of the next item holds until the output takes the waiting result.
// A new key claims the next free entry; with the table full it is dropped with
// status 2 and zero fields. Entries are only cleared by reset, which takes
// effect at once through the fill count. The result sits in an output register,
// so a new item is accepted while an earlier result still waits.
module allocation_groupby_aggregator_unit #(
    parameter int TABLE_ENTRIES = agu_pkg::DEFAULT_TABLE_ENTRIES
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    agu_stream_if.sink   i_item,
    agu_stream_if.source o_result
);
    import agu_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);

    t_cmd             w_cmd;
    t_stat            w_stat;
    logic [IDX_W-1:0] w_rd_addr;
    logic [IDX_W-1:0] w_wr_addr;
    logic             w_in_ready;
    logic             w_out_valid;
    t_out_item        w_out_payload;

    // Sequencing of lookup and update.
    agu_controller #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W),
        .FILL_W        (FILL_W)
    ) u_controller (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_rd_addr  (w_rd_addr),
        .o_wr_addr  (w_wr_addr)
    );

    // Table memory, record update and result register.
    agu_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_payload  (i_item.payload),
        .i_out_ready   (o_result.ready),
        .i_cmd         (w_cmd),
        .i_rd_addr     (w_rd_addr),
        .i_wr_addr     (w_wr_addr),
        .o_stat        (w_stat),
        .o_out_valid   (w_out_valid),
        .o_out_payload (w_out_payload)
    );

    assign i_item.ready     = w_in_ready;
    assign o_result.valid   = w_out_valid;
    assign o_result.payload = w_out_payload;

endmodule

`default_nettype wire

// ----- dv/allocation_groupby_aggregator_unit_test.sv -----
`timescale 1ns / 1ps

module allocation_groupby_aggregator_unit_test;
    import agu_pkg::*;

    localparam int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES;
    localparam int RANDOM_ITEMS  = 1240;
    localparam int POOL_KEYS     = 90;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] FIVES = 64'h5555_5555_5555_5555;
    localparam logic [63:0] TENS  = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [63:0] TOP   = 64'h8000_0000_0000_0000;

    // One row of the directed table; want is only meaningful when typed is set.
    typedef struct packed {
        t_in_item  stim;
        logic      typed;
        t_out_item want;
    } t_row;

    localparam int DIRECTED_ROWS = 14;
    localparam t_out_item NO_WANT = '0;
    localparam t_row DIRECTED [DIRECTED_ROWS] = '{
        // First item after reset claims entry 0.
        '{'{64'd0, 64'd0, 64'd0}, 1'b1, '{STATUS_NEW, 32'd1, 64'd0, 64'd0, 64'd0}},
        // Largest size and address on the same key.
        '{'{64'd0, ONES, ONES}, 1'b1, '{STATUS_UPDATED, 32'd2, ONES, ONES, ONES}},
        // The sum saturates; a smaller size keeps the peak.
        '{'{64'd0, 64'd1, 64'h1234}, 1'b1, '{STATUS_UPDATED, 32'd3, ONES, ONES, ONES}},
        '{'{ONES, 64'd100, 64'hA000}, 1'b1,
          '{STATUS_NEW, 32'd1, 64'd100, 64'd100, 64'hA000}},
        // An equal size leaves the peak address alone.
        '{'{ONES, 64'd100, 64'hB000}, 1'b1,
          '{STATUS_UPDATED, 32'd2, 64'd200, 64'd100, 64'hA000}},
        '{'{ONES, 64'd50, 64'hC000}, 1'b1,
          '{STATUS_UPDATED, 32'd3, 64'd250, 64'd100, 64'hA000}},
        // A strictly larger size moves the peak and its address.
        '{'{ONES, 64'd101, 64'hD000}, 1'b1,
          '{STATUS_UPDATED, 32'd4, 64'd351, 64'd101, 64'hD000}},
        '{'{FIVES, TENS, FIVES}, 1'b0, NO_WANT},
        '{'{TENS, FIVES, TENS}, 1'b0, NO_WANT},
        '{'{FIVES, FIVES, ONES}, 1'b0, NO_WANT},
        '{'{FIVES, 64'd1, 64'd0}, 1'b0, NO_WANT},
        '{'{TENS, 64'd0, 64'd0}, 1'b0, NO_WANT},
        '{'{TOP, TOP, TOP}, 1'b0, NO_WANT},
        // A sum that just passes the top of the range saturates.
        '{'{TOP, TOP, 64'd1}, 1'b0, NO_WANT}
    };

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_EVERY_FIFTH,
        STALL_SPARSE
    } t_stall_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic sink_ready = 1'b0;
    int   cycles = 0;
    int   failures = 0;
    int   seen_new = 0;
    int   seen_updated = 0;
    int   seen_dropped = 0;

    // Shadow copy of the aggregation table.
    logic        shadow_valid [TABLE_ENTRIES];
    logic [63:0] shadow_key   [TABLE_ENTRIES];
    logic [31:0] shadow_count [TABLE_ENTRIES];
    logic [63:0] shadow_sum   [TABLE_ENTRIES];
    logic [63:0] shadow_peak  [TABLE_ENTRIES];
    logic [63:0] shadow_addr  [TABLE_ENTRIES];

    t_out_item pending_records [$];

    agu_stream_if #(.t_payload(t_in_item))  item_ch ();
    agu_stream_if #(.t_payload(t_out_item)) result_ch ();

    assign result_ch.ready = sink_ready;

    allocation_groupby_aggregator_unit #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_result(result_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 0;
    end

    // Fold one allocation into the shadow table and return the updated record.
    function automatic t_out_item fold_into_table(t_in_item it);
        t_out_item   rec;
        int          hit;
        int          spare;
        logic [64:0] wide;
        hit   = -1;
        spare = -1;
        rec   = '0;
        for (int e = 0; e < TABLE_ENTRIES; e++) begin
            if (shadow_valid[e]) begin
                if (hit < 0 && shadow_key[e] == it.stack_key) hit = e;
            end else if (spare < 0) begin
                spare = e;
            end
        end
        if (hit >= 0) begin
            if (shadow_count[hit] != COUNT_MAX) shadow_count[hit] = shadow_count[hit] + 32'd1;
            wide = {1'b0, shadow_sum[hit]} + {1'b0, it.alloc_size};
            shadow_sum[hit] = wide[64] ? SUM_MAX : wide[63:0];
            if (shadow_peak[hit] < it.alloc_size) begin
                shadow_peak[hit] = it.alloc_size;
                shadow_addr[hit] = it.block_address;
            end
            rec = '{STATUS_UPDATED, shadow_count[hit], shadow_sum[hit],
                    shadow_peak[hit], shadow_addr[hit]};
        end else if (spare >= 0) begin
            shadow_valid[spare] = 1'b1;
            shadow_key[spare]   = it.stack_key;
            shadow_count[spare] = 32'd1;
            shadow_sum[spare]   = it.alloc_size;
            shadow_peak[spare]  = it.alloc_size;
            shadow_addr[spare]  = it.block_address;
            rec = '{STATUS_NEW, 32'd1, it.alloc_size, it.alloc_size, it.block_address};
        end else begin
            rec.status = STATUS_DROPPED;
        end
        return rec;
    endfunction

    // Cycle counter with a hard stop.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: stall modes picked at random, each held for a random stretch.
    t_stall_mode stall_mode = STALL_NONE;
    int          mode_left = 100;
    int          phase = 0;

    always @(posedge i_clk) begin
        phase <= (phase == 4) ? 0 : phase + 1;
        if (mode_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            mode_left  <= $urandom_range(50, 400);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            STALL_NONE: sink_ready <= 1'b1;
            STALL_COIN: sink_ready <= 1'($urandom_range(0, 1));
            STALL_EVERY_FIFTH: sink_ready <= (phase == 0);
            default: sink_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Compare each accepted result with the oldest expected record.
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got = result_ch.payload;
            if (pending_records.size() == 0) begin
                $error("result item arrived with no expected record waiting");
                failures = failures + 1;
            end else begin
                want = pending_records.pop_front();
                if (got.status != want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                    failures = failures + 1;
                end
                if (got.alloc_count != want.alloc_count) begin
                    $error("alloc_count: expected %0d, actual %0d",
                           want.alloc_count, got.alloc_count);
                    failures = failures + 1;
                end
                if (got.size_sum != want.size_sum) begin
                    $error("size_sum: expected %h, actual %h", want.size_sum, got.size_sum);
                    failures = failures + 1;
                end
                if (got.size_peak != want.size_peak) begin
                    $error("size_peak: expected %h, actual %h", want.size_peak, got.size_peak);
                    failures = failures + 1;
                end
                if (got.peak_address != want.peak_address) begin
                    $error("peak_address: expected %h, actual %h",
                           want.peak_address, got.peak_address);
                    failures = failures + 1;
                end
            end
            case (got.status)
                STATUS_NEW: seen_new <= seen_new + 1;
                STATUS_UPDATED: seen_updated <= seen_updated + 1;
                default: seen_dropped <= seen_dropped + 1;
            endcase
        end
    end

    // Sender: directed rows first, then random items in bursts.
    initial begin
        logic [63:0] key_pool [POOL_KEYS];
        t_in_item    stim;
        t_out_item   predicted;
        int          burst_left;
        int          gap;
        int          pick;
        for (int e = 0; e < TABLE_ENTRIES; e++) shadow_valid[e] = 1'b0;
        for (int k = 0; k < POOL_KEYS; k++) key_pool[k] = {$urandom, $urandom};
        burst_left = 0;
        item_ch.valid   <= 1'b0;
        item_ch.payload <= '0;
        i_rst_n         <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < DIRECTED_ROWS + RANDOM_ITEMS; n++) begin
            if (n < DIRECTED_ROWS) begin
                stim = DIRECTED[n].stim;
            end else begin
                // Mostly keys from a pool a bit larger than the table, so that
                // hits, fresh entries and drops on a full table all occur.
                pick = $urandom_range(0, 99);
                stim.stack_key = (pick < 88) ? key_pool[$urandom_range(0, POOL_KEYS - 1)]
                                             : {$urandom, $urandom};
                pick = $urandom_range(0, 9);
                if (pick < 5) stim.alloc_size = 64'($urandom_range(0, 4096));
                else if (pick < 8) stim.alloc_size = {$urandom, $urandom};
                else stim.alloc_size = {32'hFFFF_FFFF, $urandom};
                stim.block_address = {$urandom, $urandom};
            end
            item_ch.valid   <= 1'b1;
            item_ch.payload <= stim;
            do @(posedge i_clk); while (!item_ch.ready);

            // The item is accepted at this edge.
            predicted = fold_into_table(stim);
            if (n < DIRECTED_ROWS && DIRECTED[n].typed) pending_records.push_back(DIRECTED[n].want);
            else pending_records.push_back(predicted);

            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0) begin
                    item_ch.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end else begin
                burst_left = burst_left - 1;
            end
        end
        item_ch.valid <= 1'b0;

        while (pending_records.size() != 0) @(posedge i_clk);
        repeat (TABLE_ENTRIES + 8) @(posedge i_clk);

        $display("Ran %0d items: %0d directed, %0d random, across sender bursts and stall modes.",
                 DIRECTED_ROWS + RANDOM_ITEMS, DIRECTED_ROWS, RANDOM_ITEMS);
        $display("Results seen: %0d new entries, %0d updates, %0d dropped on a full table.",
                 seen_new, seen_updated, seen_dropped);
        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
